// ----- src/dbpg_pkg.sv -----
// shared constants, types and helper functions of the de bruijn pattern generator
// no dependencies; used by every other file of the block
package dbpg_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int WINDOW_LENGTH = 4;

  localparam int SYM_W    = $clog2(ALPHABET_SIZE);
  localparam int POS_W    = $clog2(WINDOW_LENGTH + 2);
  localparam int LEN_W    = 19;
  localparam int SYMBOL_W = 7;

  localparam logic [SYMBOL_W-1:0] ASCII_BASE = 7'd97;
  localparam logic [SYM_W-1:0]    SYM_MAX    = SYM_W'(ALPHABET_SIZE - 1);

  // alphabet size to the window length, saturated just above the length field
  function automatic longint seq_total_calc();
    longint total;
    total = 1;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      total = total * ALPHABET_SIZE;
      if (total > (longint'(1) << LEN_W) - 1) begin
        total = longint'(1) << LEN_W;
      end
    end
    return total;
  endfunction

  localparam logic [LEN_W:0] SEQ_TOTAL = (LEN_W + 1)'(seq_total_calc());

  typedef struct packed {
    logic restart;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic adv_last;
  } sts_t;

endpackage

// ----- src/dbpg_if.sv -----
// handshake channels of the de bruijn pattern generator: request, result, config
// depends on dbpg_pkg for payload widths
interface dbpg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface dbpg_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dbpg_pkg::SYMBOL_W-1:0] symbol;
  logic                          symbol_valid;
  logic                          is_last;
  modport source (output valid, output symbol, output symbol_valid, output is_last,
                  input ready);
  modport sink (input valid, input symbol, input symbol_valid, input is_last,
                output ready);
endinterface

interface dbpg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dbpg_pkg::LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/dbpg_datapath.sv -----
// datapath: current lyndon word, positions, emitted count, length register, result payload
// depends on dbpg_pkg; driven by dbpg_ctrl through cmd_t, reports through sts_t
module dbpg_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dbpg_pkg::cmd_t                cmd,
  output dbpg_pkg::sts_t                sts,
  input  logic                          cfg_write,
  input  logic [dbpg_pkg::LEN_W-1:0]    cfg_data,
  output logic [dbpg_pkg::SYMBOL_W-1:0] symbol,
  output logic                          symbol_valid,
  output logic                          is_last
);
  import dbpg_pkg::*;

  logic [SYM_W-1:0] word [WINDOW_LENGTH];
  logic [POS_W-1:0] prefix_length;
  logic [POS_W-1:0] emit_position;
  logic [LEN_W-1:0] emitted_count;
  logic             sequence_done;
  logic [LEN_W-1:0] pattern_length;

  logic [2**POS_W-1:0] div_mask;

  // which prefix lengths divide the window
  for (genvar d = 0; d < 2**POS_W; d++) begin : g_div
    if (d >= 1 && d <= WINDOW_LENGTH) begin : g_in
      localparam bit IsDiv = (WINDOW_LENGTH % d) == 0;
      assign div_mask[d] = IsDiv;
    end else begin : g_out
      assign div_mask[d] = 1'b0;
    end
  end

  // emit side
  logic [LEN_W:0]    limit;
  logic              used_up;
  logic [LEN_W-1:0]  count_inc;
  logic [POS_W-1:0]  pos_sel;
  logic [POS_W-1:0]  pos_inc;
  logic [SYM_W-1:0]  cur_sym;

  always_comb begin
    limit = ({1'b0, pattern_length} < SEQ_TOTAL) ? {1'b0, pattern_length} : SEQ_TOTAL;
    used_up = sequence_done || ({1'b0, emitted_count} >= limit);
    count_inc = emitted_count + 1'b1;
    if (emit_position < POS_W'(1) || emit_position > prefix_length ||
        emit_position > POS_W'(WINDOW_LENGTH)) begin
      pos_sel = POS_W'(1);
    end else begin
      pos_sel = emit_position;
    end
    pos_inc = pos_sel + 1'b1;
    cur_sym = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      if (pos_sel == POS_W'(i + 1)) begin
        cur_sym = word[i];
      end
    end
  end

  // successor step: periodic extension, drop trailing maxima, bump the last one left
  logic [SYM_W-1:0] ext     [WINDOW_LENGTH];
  logic [SYM_W-1:0] ext_inc [WINDOW_LENGTH];
  logic [POS_W-1:0] hit;
  logic             any_left;
  logic [POS_W-1:0] prefix_next;

  always_comb begin
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      ext[i] = word[i];
      for (int j = 0; j < i; j++) begin
        if (POS_W'(i) >= prefix_length && POS_W'(i - j) == prefix_length) begin
          ext[i] = ext[j];
        end
      end
    end
    hit = '0;
    any_left = 1'b0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      if (ext[i] < SYM_MAX) begin
        hit = POS_W'(i);
        any_left = 1'b1;
      end
    end
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      ext_inc[i] = (hit == POS_W'(i)) ? ext[i] + 1'b1 : ext[i];
    end
    prefix_next = any_left ? hit + 1'b1 : prefix_length;
  end

  assign sts.wrap     = !used_up && (pos_inc > prefix_length);
  assign sts.adv_last = !any_left || div_mask[prefix_next];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        word[i] <= '0;
      end
      prefix_length  <= POS_W'(1);
      emit_position  <= POS_W'(1);
      emitted_count  <= '0;
      sequence_done  <= 1'b0;
      pattern_length <= '0;
    end else begin
      if (cfg_write) begin
        pattern_length <= cfg_data;
      end
      if (cmd.restart) begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
          word[i] <= '0;
        end
        prefix_length <= POS_W'(1);
        emit_position <= POS_W'(1);
        emitted_count <= '0;
        sequence_done <= 1'b0;
      end else if (cmd.emit) begin
        if (!used_up) begin
          emitted_count <= count_inc;
          emit_position <= (pos_inc > prefix_length) ? POS_W'(1) : pos_inc;
        end
      end else if (cmd.advance) begin
        if (any_left) begin
          for (int i = 0; i < WINDOW_LENGTH; i++) begin
            word[i] <= ext_inc[i];
          end
          prefix_length <= prefix_next;
        end else begin
          for (int i = 0; i < WINDOW_LENGTH; i++) begin
            word[i] <= ext[i];
          end
          sequence_done <= 1'b1;
        end
      end
    end
  end

  // result payload, loaded when the item is emitted
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (used_up) begin
        symbol       <= '0;
        symbol_valid <= 1'b0;
        is_last      <= 1'b0;
      end else begin
        symbol       <= ASCII_BASE + SYMBOL_W'(cur_sym);
        symbol_valid <= 1'b1;
        is_last      <= ({1'b0, count_inc} == limit);
      end
    end
  end

endmodule

// ----- src/dbpg_ctrl.sv -----
// controller: sequences accept, emit and lyndon advance, owns the result valid flag
// depends on dbpg_pkg for the command and status structs
module dbpg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_restart,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dbpg_pkg::cmd_t cmd,
  input  dbpg_pkg::sts_t sts
);
  import dbpg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_ADV
  } state_t;

  state_t state;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.restart = (state == S_IDLE) && req_valid && req_restart;
    cmd.emit    = (state == S_EMIT) && rsp_free;
    cmd.advance = (state == S_ADV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            state <= sts.wrap ? S_ADV : S_IDLE;
          end
        end
        S_ADV: begin
          // keep stepping until a word whose length divides the window, or the end
          if (sts.adv_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/de_bruijn_pattern_generator_core.sv -----
// De Bruijn pattern generator, alphabet a..z, window 4, built by concatenating Lyndon words.
// Each request item yields one result item: the next character of the sequence, or an
// invalid symbol once the configured length (saturated at 26^4) is used up. An item is
// accepted, then emitted into the result register once that register is free; when the
// character is the last of its Lyndon word, the successor unit then steps the word once
// per cycle until a word whose length divides the window appears, in at most two steps.
// The result register lets the next item be accepted while a result still waits. Length
// writes are taken at any time and do not restart the sequence.
module de_bruijn_pattern_generator_core (
  input  logic           clk,
  input  logic           rst,
  dbpg_req_if.sink       req,
  dbpg_rsp_if.source     rsp,
  dbpg_cfg_if.sink       cfg
);
  import dbpg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  dbpg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_restart (req.restart),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  dbpg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg.data),
    .symbol       (rsp.symbol),
    .symbol_valid (rsp.symbol_valid),
    .is_last      (rsp.is_last)
  );

endmodule
